// ===== src/tmtw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared constants, types and helpers for the text-mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

	// Screen geometry
	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int MOVE_COUNT    = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

	// Widths
	localparam int AW       = $clog2(CELL_COUNT);
	localparam int COL_W    = $clog2(SCREEN_WIDTH);
	localparam int LINE_W   = $clog2(SCREEN_HEIGHT);
	localparam int POS_W    = 11;
	localparam int IDX_W    = 11;
	localparam int CMD_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int COLOUR_W = 4;
	localparam int CELL_W   = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
	localparam logic [CHAR_W-1:0] CH_PRINT_MIN = 8'h20;

	localparam int TAB_STEP = 8;

	// White space on black
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	// Cursor update for one put
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [LINE_W-1:0] line;
		logic              wr;
		logic              scroll;
	} cur_next_t;

	// Linear cell address of a cursor
	function automatic logic [AW-1:0] cell_pos(input logic [COL_W-1:0] col,
			input logic [LINE_W-1:0] line);
		cell_pos = AW'(line * SCREEN_WIDTH + col);
	endfunction

	// Reported position, masked to the result width
	function automatic logic [POS_W-1:0] pos_out(input logic [AW-1:0] pos);
		logic [AW+POS_W-1:0] wide;
		wide = {{POS_W{1'b0}}, pos};
		pos_out = wide[POS_W-1:0];
	endfunction

endpackage

// ===== src/tmtw_if.sv =====
// ----------------------------------------------------------------------------
// tmtw request and result channels
// Valid/ready channels carrying terminal requests and their results.
// ----------------------------------------------------------------------------
interface tmtw_req_if;
	logic                              valid;
	logic                              ready;
	logic [tmtw_pkg::CMD_W-1:0]        command;
	logic [tmtw_pkg::CHAR_W-1:0]       char_code;
	logic [tmtw_pkg::COLOUR_W-1:0]     back_colour;
	logic [tmtw_pkg::COLOUR_W-1:0]     fore_colour;
	logic [tmtw_pkg::IDX_W-1:0]        cell_index;

	modport source(output valid, command, char_code, back_colour, fore_colour, cell_index,
		input ready);
	modport sink(input valid, command, char_code, back_colour, fore_colour, cell_index,
		output ready);
endinterface

interface tmtw_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [tmtw_pkg::POS_W-1:0]        cursor_position;
	logic [tmtw_pkg::CELL_W-1:0]       cell_value;

	modport source(output valid, cursor_position, cell_value, input ready);
	modport sink(input valid, cursor_position, cell_value, output ready);
endinterface

// ===== src/text_mode_terminal_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Text-mode console: screen memory of 16-bit cells plus cursor, driven by
// put, clear and read requests. One result per request.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------
//  req     | in  | command, char_code, back_colour, fore_colour, cell_index
//  rsp     | out | cursor_position, cell_value
//
//  A put that does not scroll, read and no-op go from the request to ST_DONE, which loads the result reg.
//  A put that scrolls walks the screen RAM: it moves each row but the first up
//  one row, then fills the bottom row with blanks; clear fills every cell. The
//  single write port of the screen RAM makes both walk the RAM cell by cell.
//  Reset clears cursor and control state; screen RAM contents are undefined.
//  A new request is taken while the previous result waits in the output reg.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer (
	input  logic       clk,
	input  logic       arst_n,
	tmtw_req_if.sink   req,
	tmtw_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCROLL = 2'd1;
	localparam logic [1:0] ST_FILL   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	localparam logic [tmtw_pkg::AW-1:0] MOVE_LAST  = tmtw_pkg::AW'(tmtw_pkg::MOVE_COUNT);
	localparam logic [tmtw_pkg::AW-1:0] CELL_LAST  = tmtw_pkg::AW'(tmtw_pkg::CELL_COUNT - 1);
	localparam logic [tmtw_pkg::AW-1:0] ROW_OFFSET = tmtw_pkg::AW'(tmtw_pkg::SCREEN_WIDTH);

	logic [1:0]                    state_q;
	logic [tmtw_pkg::COL_W-1:0]    col_q;
	logic [tmtw_pkg::LINE_W-1:0]   line_q;
	logic [tmtw_pkg::AW-1:0]       ptr_q;
	logic                          rd_ok_q;
	logic                          mv_s1;
	logic [tmtw_pkg::AW-1:0]       mv_dst_s1;
	logic                          out_valid_q;
	logic [tmtw_pkg::POS_W-1:0]    out_pos_q;
	logic [tmtw_pkg::CELL_W-1:0]   out_cell_q;

	logic [tmtw_pkg::CELL_W-1:0]   mem [tmtw_pkg::CELL_COUNT];
	logic [tmtw_pkg::CELL_W-1:0]   rdata_q;

	logic                          accept;
	logic                          out_free;
	logic                          idx_ok;
	tmtw_pkg::cur_next_t           cur_nxt;
	logic [tmtw_pkg::AW-1:0]       cur_pos;
	logic                          wr_en;
	logic [tmtw_pkg::AW-1:0]       wr_addr;
	logic [tmtw_pkg::CELL_W-1:0]   wr_data;
	logic                          rd_en;
	logic [tmtw_pkg::AW-1:0]       rd_addr;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign idx_ok    = (req.cell_index < tmtw_pkg::IDX_W'(tmtw_pkg::CELL_COUNT))
		|| (tmtw_pkg::CELL_COUNT > (1 << tmtw_pkg::IDX_W));
	assign cur_pos   = tmtw_pkg::cell_pos(col_q, line_q);

	tmtw_cursor u_cursor (
		.col       (col_q),
		.line      (line_q),
		.char_code (req.char_code),
		.nxt       (cur_nxt)
	);

	// Screen RAM write port: put, scroll move or blank fill
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = tmtw_pkg::BLANK_CELL;
		case (state_q)
			ST_IDLE: begin
				wr_en   = accept && (req.command == tmtw_pkg::CMD_PUT) && cur_nxt.wr;
				wr_addr = cur_pos;
				wr_data = {req.back_colour, req.fore_colour, req.char_code};
			end
			ST_SCROLL: begin
				wr_en   = mv_s1;
				wr_addr = mv_dst_s1;
				wr_data = rdata_q;
			end
			ST_FILL: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Screen RAM read port: cell read or scroll source
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = tmtw_pkg::AW'(req.cell_index);
		case (state_q)
			ST_IDLE: begin
				rd_en = accept && (req.command == tmtw_pkg::CMD_READ) && idx_ok;
			end
			ST_SCROLL: begin
				rd_en   = (ptr_q != MOVE_LAST);
				rd_addr = ptr_q + ROW_OFFSET;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Screen RAM
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Scroll move pipeline: read at ptr+WIDTH, write to ptr in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= (state_q == ST_SCROLL) && (ptr_q != MOVE_LAST);
		end
	end

	always_ff @(posedge clk) begin
		mv_dst_s1 <= ptr_q;
	end

	// Sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			line_q  <= '0;
			ptr_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_ok_q <= 1'b0;
						ptr_q   <= '0;
						case (req.command)
							tmtw_pkg::CMD_PUT: begin
								col_q   <= cur_nxt.col;
								line_q  <= cur_nxt.line;
								state_q <= cur_nxt.scroll ? ST_SCROLL : ST_DONE;
							end
							tmtw_pkg::CMD_CLEAR: begin
								col_q   <= '0;
								line_q  <= '0;
								state_q <= ST_FILL;
							end
							tmtw_pkg::CMD_READ: begin
								rd_ok_q <= idx_ok;
								state_q <= ST_DONE;
							end
							tmtw_pkg::CMD_NOP: begin
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCROLL: begin
					// Last cycle drains the final move, then blank the bottom row
					if (ptr_q == MOVE_LAST) begin
						state_q <= ST_FILL;
					end else begin
						ptr_q <= ptr_q + tmtw_pkg::AW'(1);
					end
				end
				ST_FILL: begin
					if (ptr_q == CELL_LAST) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + tmtw_pkg::AW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_pos_q  <= tmtw_pkg::pos_out(cur_pos);
			out_cell_q <= rd_ok_q ? rdata_q : '0;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.cursor_position = out_pos_q;
	assign rsp.cell_value      = out_cell_q;

endmodule

// ===== src/tmtw_cursor.sv =====
// ----------------------------------------------------------------------------
// tmtw_cursor
// Next cursor, cell write enable and scroll flag for one put request.
// ----------------------------------------------------------------------------
module tmtw_cursor (
	input  logic [tmtw_pkg::COL_W-1:0]  col,
	input  logic [tmtw_pkg::LINE_W-1:0] line,
	input  logic [tmtw_pkg::CHAR_W-1:0] char_code,
	output tmtw_pkg::cur_next_t         nxt
);

	logic [tmtw_pkg::LINE_W:0] line_w;
	logic [tmtw_pkg::COL_W:0]  tab_sum;

	assign tab_sum = {1'b0, col} + (tmtw_pkg::COL_W + 1)'(tmtw_pkg::TAB_STEP);

	// BS, TAB, LF and CR move the cursor; printable codes write and advance; other codes are ignored
	always_comb begin
		nxt.col = col;
		nxt.wr  = 1'b0;
		line_w  = {1'b0, line};
		case (char_code)
			tmtw_pkg::CH_BS: begin
				if (col != '0) begin
					nxt.col = col - tmtw_pkg::COL_W'(1);
				end else if (line != '0) begin
					nxt.col = tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH - 1);
					line_w  = line_w - (tmtw_pkg::LINE_W + 1)'(1);
				end
			end
			tmtw_pkg::CH_LF: begin
				nxt.col = '0;
				line_w  = line_w + (tmtw_pkg::LINE_W + 1)'(1);
			end
			tmtw_pkg::CH_CR: begin
				nxt.col = '0;
			end
			tmtw_pkg::CH_TAB: begin
				if (col < tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH - tmtw_pkg::TAB_STEP)) begin
					nxt.col = tab_sum[tmtw_pkg::COL_W-1:0]
						& ~tmtw_pkg::COL_W'(tmtw_pkg::TAB_STEP - 1);
				end else begin
					nxt.col = tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH - 1);
				end
			end
			default: begin
				if (char_code >= tmtw_pkg::CH_PRINT_MIN) begin
					nxt.wr = 1'b1;
					if (col == tmtw_pkg::COL_W'(tmtw_pkg::SCREEN_WIDTH - 1)) begin
						nxt.col = '0;
						line_w  = line_w + (tmtw_pkg::LINE_W + 1)'(1);
					end else begin
						nxt.col = col + tmtw_pkg::COL_W'(1);
					end
				end
			end
		endcase

		// Past the bottom line: scroll and stay on the last line
		nxt.scroll = (line_w == (tmtw_pkg::LINE_W + 1)'(tmtw_pkg::SCREEN_HEIGHT));
		if (nxt.scroll) begin
			nxt.line = tmtw_pkg::LINE_W'(tmtw_pkg::SCREEN_HEIGHT - 1);
		end else begin
			nxt.line = line_w[tmtw_pkg::LINE_W-1:0];
		end
	end

endmodule

// ===== src/tmtw_checker.sv =====
// ----------------------------------------------------------------------------
// tmtw_checker
// Port-level checks for the text-mode terminal writer, bound to the top.
// ----------------------------------------------------------------------------
module tmtw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [tmtw_pkg::POS_W-1:0]    cursor_position,
	input logic [tmtw_pkg::CELL_W-1:0]   cell_value
);

	// A stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_position)
			&& $stable(cell_value))
		else $error("result changed while stalled");

	// A taken request leaves the block busy, so requests are never taken back to back
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken on consecutive cycles");

	// A new result only comes out of a busy cycle
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without a request in flight");

	// Cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (tmtw_pkg::CELL_COUNT > (1 << tmtw_pkg::POS_W))
			|| (cursor_position < tmtw_pkg::POS_W'(tmtw_pkg::CELL_COUNT)))
		else $error("cursor position off screen");

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.cursor_position (rsp.cursor_position),
	.cell_value      (rsp.cell_value)
);
